// ===== rtl/core/nsr_pkg.sv =====
package nsr_pkg;

    // field widths fixed by the word format
    localparam int unsigned STATE_FIELD_W  = 4;
    localparam int unsigned SLOT_FIELD_W   = 3;
    localparam int unsigned SYM_FIELD_W    = 8;
    localparam int unsigned SYM_WIDE_W     = 16;
    localparam int unsigned CFG_W          = 5;

    localparam logic [CFG_W-1:0]       STATE_COUNT_RST = 5'd2;
    localparam logic [SYM_FIELD_W-1:0] SYM_FIELD_MASK  = 8'hff;

    // action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SYMBOL = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [STATE_FIELD_W-1:0] entry_state;
        logic [SLOT_FIELD_W-1:0]  entry_slot;
        logic [SYM_FIELD_W-1:0]   entry_symbol;
        logic [STATE_FIELD_W-1:0] entry_target;
        logic                     entry_valid;
        logic [SYM_FIELD_W-1:0]   symbol;
        logic                     last;
    } t_in_word;

    typedef struct packed {
        logic alive;
        logic accepted;
        logic string_end;
    } t_out_word;

    // table write request
    typedef struct packed {
        logic                     en;
        logic [STATE_FIELD_W-1:0] state;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [SYM_FIELD_W-1:0]   symbol;
        logic [STATE_FIELD_W-1:0] target;
        logic                     valid;
    } t_tbl_wr;

endpackage

// ===== rtl/core/nsr_if.sv =====
interface nsr_in_if
    import nsr_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nsr_out_if
    import nsr_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/nsr_in_stage.sv =====
module nsr_in_stage
    import nsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    nsr_in_if.sink     i_ch,
    input  logic       i_out_free,
    output logic       o_fire,
    output t_in_word   o_word
);

    logic     r_valid;
    t_in_word r_word;
    logic     fire;

    // loads never need the result register
    assign fire       = r_valid && ((r_word.action == ACT_LOAD) || i_out_free);
    assign i_ch.ready = !r_valid || fire;
    assign o_fire     = fire;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ch.valid && i_ch.ready) begin
            r_valid <= 1'b1;
        end else if (fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ch.valid && i_ch.ready) begin
            r_word <= i_ch.data;
        end
    end

endmodule

// ===== rtl/core/nsr_table.sv =====
module nsr_table
    import nsr_pkg::*;
#(
    parameter int unsigned MAX_STATES      = 16,
    parameter int unsigned MAX_TRANSITIONS = 8,
    parameter int unsigned SYMBOL_BITS     = 8,
    parameter int unsigned NW              = 5
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tbl_wr                i_wr,
    input  logic [MAX_STATES-1:0]  i_active,
    input  logic [NW-1:0]          i_count,
    input  logic [SYM_FIELD_W-1:0] i_symbol,
    output logic [MAX_STATES-1:0]  o_next
);

    typedef logic [MAX_STATES-1:0]  t_set;
    typedef logic [SYMBOL_BITS-1:0] t_sym;

    t_sym                     r_sym [MAX_STATES][MAX_TRANSITIONS];
    logic [STATE_FIELD_W-1:0] r_tgt [MAX_STATES][MAX_TRANSITIONS];
    logic                     r_vld [MAX_STATES][MAX_TRANSITIONS];

    logic [SYM_WIDE_W-1:0] wr_sym_wide;
    logic [SYM_WIDE_W-1:0] ch_wide;
    t_sym                  ch;

    // character taken as its low symbol bits
    assign wr_sym_wide = {{(SYM_WIDE_W-SYM_FIELD_W){1'b0}}, i_wr.symbol & SYM_FIELD_MASK};
    assign ch_wide     = {{(SYM_WIDE_W-SYM_FIELD_W){1'b0}}, i_symbol & SYM_FIELD_MASK};
    assign ch          = ch_wide[SYMBOL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < int'(MAX_STATES); s++) begin
            for (int k = 0; k < int'(MAX_TRANSITIONS); k++) begin
                if (!i_rst_n) begin
                    r_vld[s][k] <= 1'b0;
                end else if (i_wr.en && (32'(i_wr.state) == 32'(s))
                             && (32'(i_wr.slot) == 32'(k))) begin
                    r_vld[s][k] <= i_wr.valid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < int'(MAX_STATES); s++) begin
            for (int k = 0; k < int'(MAX_TRANSITIONS); k++) begin
                if (i_wr.en && (32'(i_wr.state) == 32'(s)) && (32'(i_wr.slot) == 32'(k))) begin
                    r_sym[s][k] <= wr_sym_wide[SYMBOL_BITS-1:0];
                    r_tgt[s][k] <= i_wr.target;
                end
            end
        end
    end

    // every entry compares against the character in parallel
    always_comb begin
        o_next = '0;
        for (int s = 0; s < int'(MAX_STATES); s++) begin
            for (int k = 0; k < int'(MAX_TRANSITIONS); k++) begin
                if (r_vld[s][k] && (r_sym[s][k] == ch) && i_active[s]
                    && (32'(s) < 32'(i_count))
                    && (32'(r_tgt[s][k]) < 32'(i_count))) begin
                    o_next = o_next | (t_set'(1) << r_tgt[s][k]);
                end
            end
        end
    end

endmodule

// ===== rtl/core/nfa_string_recognizer.sv =====
// nfa_string_recognizer: bit-parallel nfa run over a character stream
//
// i_sym_ch (valid/ready) carries one word per item. action load writes one
// transition entry (source state, slot, symbol, target, valid); action
// symbol advances the active-state set and yields one result word on
// o_res_ch (alive, accepted, string_end). loads yield nothing.
// i_cfg_we/i_cfg_data write state_count; write it only while idle.
//
// path: a word sits in the input register, then the next set is formed
// from all table entries at once and lands in the result register.
// throughput: one word per cycle while the result register can take a
// result (loads never wait on it), set by the update of the active set
// from the table compare.
//
// reset: all entry valid bits clear, active set holds the start state only,
// state_count is 2. when the receiver stalls the result register holds;
// the input register still takes one more word; a symbol word then waits
// there and ready drops, while load words keep passing through.
module nfa_string_recognizer
    import nsr_pkg::*;
#(
    parameter int unsigned MAX_STATES      = 16,
    parameter int unsigned MAX_TRANSITIONS = 8,
    parameter int unsigned SYMBOL_BITS     = 8
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    nsr_in_if.sink           i_sym_ch,
    nsr_out_if.source        o_res_ch
);

    localparam int unsigned NW = $clog2(MAX_STATES + 1);
    localparam int unsigned SW = $clog2(MAX_STATES);

    typedef logic [MAX_STATES-1:0] t_set;

    // config register
    logic [CFG_W-1:0] r_state_count;
    logic [31:0]      cnt_wide;
    logic [NW-1:0]    n_use;
    logic [NW-1:0]    n_last;

    // pipeline
    logic      fire;
    t_in_word  word;
    logic      out_free;
    logic      sym_fire;
    t_tbl_wr   tbl_wr;
    t_set      next_set;
    t_set      r_active;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= STATE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_state_count <= i_cfg_data;
        end
    end

    // clamp to 1..MAX_STATES
    assign cnt_wide = 32'(r_state_count);
    always_comb begin
        priority if (cnt_wide == 32'd0) begin
            n_use = NW'(1);
        end else if (cnt_wide > 32'(MAX_STATES)) begin
            n_use = NW'(MAX_STATES);
        end else begin
            n_use = NW'(cnt_wide);
        end
    end
    assign n_last = n_use - NW'(1);

    assign out_free = !r_out_valid || o_res_ch.ready;

    nsr_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch       (i_sym_ch),
        .i_out_free (out_free),
        .o_fire     (fire),
        .o_word     (word)
    );

    assign sym_fire      = fire && (word.action == ACT_SYMBOL);
    assign tbl_wr.en     = fire && (word.action == ACT_LOAD);
    assign tbl_wr.state  = word.entry_state;
    assign tbl_wr.slot   = word.entry_slot;
    assign tbl_wr.symbol = word.entry_symbol;
    assign tbl_wr.target = word.entry_target;
    assign tbl_wr.valid  = word.entry_valid;

    nsr_table #(
        .MAX_STATES      (MAX_STATES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS),
        .SYMBOL_BITS     (SYMBOL_BITS),
        .NW              (NW)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (tbl_wr),
        .i_active (r_active),
        .i_count  (n_use),
        .i_symbol (word.symbol),
        .o_next   (next_set)
    );

    assign n_out_word.alive      = |next_set;
    assign n_out_word.accepted   = word.last && next_set[n_last[SW-1:0]];
    assign n_out_word.string_end = word.last;

    // active set: back to the start state after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= t_set'(1);
        end else if (sym_fire) begin
            r_active <= word.last ? t_set'(1) : next_set;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (sym_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sym_fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_res_ch.valid = r_out_valid;
    assign o_res_ch.data  = r_out_word;

    // the set returns to the start state after a string ends
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sym_fire && word.last) |=> (r_active == t_set'(1)))
        else $error("active set not restarted after last character");

    // alive matches the set left behind in the middle of a string
    a_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sym_fire && !word.last) |=> (r_out_word.alive == (r_active != '0)))
        else $error("alive flag disagrees with active set");

    // acceptance only on a live last character
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.accepted) |-> (r_out_word.alive && r_out_word.string_end))
        else $error("accepted without alive last character");

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import nsr_pkg::*;

    localparam int NUM_STATES  = 16;
    localparam int NUM_SLOTS   = 8;
    localparam int WORD_TARGET = 700;
    localparam int CLEAR_WAIT  = 4;      // margin for a trailing load to leave the input register
    localparam int HOLD_CYCLES = 60;     // long receiver hold-off
    localparam int RUN_LIMIT   = 2000000;

    typedef enum bit {ROW_WORD, ROW_CFG} t_row_kind;

    // one line of the directed script
    typedef struct {
        t_row_kind        kind;
        t_in_word         w;
        logic [CFG_W-1:0] cfg;
        bit               typed;
        t_out_word        want;
    } t_script_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    nsr_in_if  sym_ch ();
    nsr_out_if res_ch ();

    nfa_string_recognizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sym_ch   (sym_ch),
        .o_res_ch   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the automaton: table, active set and state_count
    logic [SYM_FIELD_W-1:0]   tbl_sym [NUM_STATES][NUM_SLOTS];
    logic [STATE_FIELD_W-1:0] tbl_tgt [NUM_STATES][NUM_SLOTS];
    bit                       tbl_on  [NUM_STATES][NUM_SLOTS];
    logic [NUM_STATES-1:0]    live_states;
    logic [CFG_W-1:0]         count_reg;

    t_out_word   pending_results[$];
    t_script_row script[$];
    int          mismatches  = 0;
    int          words_sent  = 0;
    int          burst_left  = 0;
    bit          hold_req    = 1'b0;

    // zero runs as one state, anything past the table as the full table
    function automatic int states_in_use(logic [CFG_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > NUM_STATES)
            return NUM_STATES;
        return int'(c);
    endfunction

    // one word through the automaton: loads write the table, symbols step the set
    task automatic nfa_step(input t_in_word w, output bit produces, output t_out_word r);
        int                    n;
        logic [NUM_STATES-1:0] nxt;
        n        = states_in_use(count_reg);
        produces = 1'b0;
        r        = '0;
        nxt      = '0;
        if (w.action == ACT_LOAD) begin
            tbl_sym[w.entry_state][w.entry_slot] = w.entry_symbol;
            tbl_tgt[w.entry_state][w.entry_slot] = w.entry_target;
            tbl_on[w.entry_state][w.entry_slot]  = w.entry_valid;
            return;
        end
        // states past the count neither fire nor get set
        for (int s = 0; s < n; s++) begin
            if (live_states[s]) begin
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (tbl_on[s][k] && tbl_sym[s][k] == w.symbol && tbl_tgt[s][k] < n)
                        nxt[tbl_tgt[s][k]] = 1'b1;
                end
            end
        end
        r.alive      = |nxt;
        r.accepted   = w.last && nxt[n-1];
        r.string_end = w.last;
        live_states  = w.last ? NUM_STATES'(1) : nxt;
        produces     = 1'b1;
    endtask

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    // offer one word, bursty: a new burst may start after a gap with valid low
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        int        gap;
        bit        produces;
        t_out_word predicted;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                if (sym_ch.valid)
                    sym_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        sym_ch.valid <= 1'b1;
        sym_ch.data  <= w;
        // ready and valid as they stood just before the edge
        do @(posedge i_clk); while (!sym_ch.ready);
        words_sent++;
        nfa_step(w, produces, predicted);
        if (produces)
            pending_results.push_back(typed ? want : predicted);
    endtask

    // stop offering, let every result come home, then cover a trailing load
    task automatic wait_idle();
        if (sym_ch.valid)
            sym_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (CLEAR_WAIT) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_state_count(input logic [CFG_W-1:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        count_reg  = v;
    endtask

    function automatic t_script_row load_row(logic [3:0] st, logic [2:0] sl, logic [7:0] sym,
                                             logic [3:0] tg, logic v);
        t_script_row r;
        r                = '{kind: ROW_WORD, w: '0, cfg: '0, typed: 1'b0, want: '0};
        r.w.action       = ACT_LOAD;
        r.w.entry_state  = st;
        r.w.entry_slot   = sl;
        r.w.entry_symbol = sym;
        r.w.entry_target = tg;
        r.w.entry_valid  = v;
        return r;
    endfunction

    function automatic t_script_row sym_row(logic [7:0] sym, logic last, bit typed = 1'b0,
                                            logic alive = 1'b0, logic acc = 1'b0);
        t_script_row r;
        r          = '{kind: ROW_WORD, w: '0, cfg: '0, typed: typed, want: '0};
        r.w.action = ACT_SYMBOL;
        r.w.symbol = sym;
        r.w.last   = last;
        r.want     = '{alive: alive, accepted: acc, string_end: last};
        return r;
    endfunction

    function automatic t_script_row cfg_row(logic [CFG_W-1:0] v);
        return '{kind: ROW_CFG, w: '0, cfg: v, typed: 1'b0, want: '0};
    endfunction

    // result checker: every accepted result word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("result word %b with nothing pending", res_ch.data));
            end else begin
                want = pending_results.pop_front();
                if (res_ch.data.alive !== want.alive)
                    report($sformatf("alive expected %b got %b", want.alive,
                                     res_ch.data.alive));
                if (res_ch.data.accepted !== want.accepted)
                    report($sformatf("accepted expected %b got %b", want.accepted,
                                     res_ch.data.accepted));
                if (res_ch.data.string_end !== want.string_end)
                    report($sformatf("string_end expected %b got %b", want.string_end,
                                     res_ch.data.string_end));
            end
        end
    end

    // receiver: rotating ready masks, some all-ones, plus one long hold-off on request
    initial begin
        logic [7:0] stall_mask;
        int         mask_pos;
        int         pattern_left;
        stall_mask   = 8'hff;
        mask_pos     = 0;
        pattern_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (pattern_left == 0) begin
                    stall_mask   = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(1, 255));
                    pattern_left = $urandom_range(16, 80);
                end
                res_ch.ready <= stall_mask[mask_pos];
                mask_pos     = (mask_pos + 1) % 8;
                pattern_left--;
            end
        end
    end

    // hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // stimulus: reset, directed script, then random automata with strings over them
    initial begin
        t_in_word         w;
        logic [63:0]      noise;
        logic [CFG_W-1:0] cfg_pick;
        logic [7:0]       alpha_base;
        int               alpha_n;
        int               n_use;
        int               n_loads;
        int               n_strings;
        int               str_len;
        int               phase;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        sym_ch.valid <= 1'b0;
        sym_ch.data  <= '0;

        for (int s = 0; s < NUM_STATES; s++)
            for (int k = 0; k < NUM_SLOTS; k++) begin
                tbl_sym[s][k] = '0;
                tbl_tgt[s][k] = '0;
                tbl_on[s][k]  = 1'b0;
            end
        live_states = NUM_STATES'(1);
        count_reg   = STATE_COUNT_RST;

        // empty table after reset: nothing fires, ever
        script.push_back(sym_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        script.push_back(sym_row(8'hff, 1'b1, 1'b1, 1'b0, 1'b0));
        // small automaton: 0 -a-> 1, 1 loops on ff from the top slot
        script.push_back(load_row(4'd0, 3'd0, 8'h61, 4'd1, 1'b1));
        script.push_back(load_row(4'd1, 3'd7, 8'hff, 4'd1, 1'b1));
        // target past the two states in use
        script.push_back(load_row(4'd0, 3'd1, 8'h00, 4'd15, 1'b1));
        script.push_back(sym_row(8'h61, 1'b0));
        script.push_back(sym_row(8'hff, 1'b1));
        script.push_back(sym_row(8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
        // set dies on an unknown character and stays dead to the string's end
        script.push_back(sym_row(8'h62, 1'b0, 1'b1, 1'b0, 1'b0));
        script.push_back(sym_row(8'h61, 1'b1, 1'b1, 1'b0, 1'b0));
        // entry of a state not in use, and a slot left invalid
        script.push_back(load_row(4'd15, 3'd7, 8'h00, 4'd0, 1'b1));
        script.push_back(load_row(4'd0, 3'd2, 8'h5a, 4'd0, 1'b0));
        script.push_back(sym_row(8'h5a, 1'b1, 1'b1, 1'b0, 1'b0));
        // full table: state 15 accepts, and its entry now takes part
        script.push_back(cfg_row(5'd16));
        script.push_back(sym_row(8'h00, 1'b1));
        script.push_back(sym_row(8'h00, 1'b0));
        script.push_back(sym_row(8'h00, 1'b1));
        script.push_back(load_row(4'd0, 3'd3, 8'h5a, 4'd0, 1'b1));
        // count zero runs as one state, the start state accepts
        script.push_back(cfg_row(5'd0));
        script.push_back(sym_row(8'h5a, 1'b1));
        script.push_back(sym_row(8'h61, 1'b1));
        // count past the table size runs as sixteen
        script.push_back(cfg_row(5'd31));
        script.push_back(sym_row(8'h00, 1'b1));
        script.push_back(cfg_row(5'd1));
        script.push_back(sym_row(8'h5a, 1'b0));
        script.push_back(sym_row(8'h5a, 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG)
                write_state_count(script[i].cfg);
            else
                send_word(script[i].w, script[i].typed, script[i].want);
        end

        // random phases: pick a count, load a well-formed automaton, run strings
        phase = 0;
        while (words_sent < WORD_TARGET) begin
            case ($urandom_range(0, 9))
                0:       cfg_pick = 5'd0;
                1:       cfg_pick = CFG_W'($urandom_range(17, 31));
                2:       cfg_pick = 5'd16;
                3:       cfg_pick = 5'd1;
                default: cfg_pick = CFG_W'($urandom_range(2, 15));
            endcase
            write_state_count(cfg_pick);
            n_use      = states_in_use(cfg_pick);
            alpha_base = 8'($urandom_range(0, 255));
            alpha_n    = $urandom_range(1, 4);

            n_loads = $urandom_range(n_use, 3 * n_use);
            if (n_loads > 24)
                n_loads = 24;
            for (int i = 0; i < n_loads; i++) begin
                noise = {$urandom, $urandom};
                w     = noise[$bits(t_in_word)-1:0];
                w.action = ACT_LOAD;
                // most loads stay inside the states in use and the phase alphabet
                if ($urandom_range(0, 7) != 0) begin
                    w.entry_state  = STATE_FIELD_W'($urandom_range(0, n_use - 1));
                    w.entry_target = STATE_FIELD_W'($urandom_range(0, n_use - 1));
                    w.entry_symbol = alpha_base + 8'($urandom_range(0, alpha_n - 1));
                    w.entry_valid  = ($urandom_range(0, 7) != 0);
                end
                send_word(w, 1'b0, '0);
            end

            // once: stall the receiver while the sender keeps pushing
            if (phase == 1) begin
                hold_req   = 1'b1;
                burst_left = 200;
            end

            n_strings = $urandom_range(3, 10);
            for (int j = 0; j < n_strings; j++) begin
                str_len = $urandom_range(1, 8);
                for (int c = 0; c < str_len; c++) begin
                    noise = {$urandom, $urandom};
                    w     = noise[$bits(t_in_word)-1:0];
                    // a stray table write now and then, mid-string
                    if ($urandom_range(0, 15) == 0) begin
                        w.action = ACT_LOAD;
                        send_word(w, 1'b0, '0);
                        noise = {$urandom, $urandom};
                        w     = noise[$bits(t_in_word)-1:0];
                    end
                    w.action = ACT_SYMBOL;
                    if ($urandom_range(0, 9) != 0)
                        w.symbol = alpha_base + 8'($urandom_range(0, alpha_n - 1));
                    w.last = (c == str_len - 1);
                    send_word(w, 1'b0, '0);
                end
            end
            phase++;
        end

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
